@@ design/bsa_pkg.sv @@
`timescale 1ns / 1ps

package bsa_pkg;

   // default map size in bytes, eight slots to a byte
   localparam int BSA_MAP_BYTES = 32;
   // bytes covered by one group of the two-level free search
   localparam int BSA_GROUP_BYTES = 32;

   // request kinds
   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_CLEAR = 2'd2
   } bsa_func_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_USED = 2'd2
   } bsa_status_type;

   // request payload
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] slot_in;
   } bsa_req_type;

   // response payload
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] slot_out;
      logic [8:0] used_count;
   } bsa_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // latch and decode the incoming request
      logic load_byte;  // pick the first byte with a free slot
      logic read;       // read the addressed map byte
      logic rescan;     // hinted slot was busy, fall back to the scan
      logic update;     // write back state and load the response
   } bsa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic go_scan;    // incoming request needs the first-free search
      logic go_read;    // incoming request needs a map byte
      logic hint_miss;  // hinted slot found busy
      logic rsp_free;   // response register can take a new response
   } bsa_stat_type;

endpackage

@@ design/bsa_ctrl.sv @@
`timescale 1ns / 1ps

module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsa_pkg::bsa_stat_type stat,
   output bsa_pkg::bsa_cmd_type  cmd
);
   import bsa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BYTE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_UPDATE = 4'b1000
   } bsa_state_type;

   bsa_state_type state_ff, state_in;

   // requests are taken only when no request is in flight
   assign req_stall = (state_ff != ST_IDLE);

   // sequencing
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.go_scan) begin
                  state_in = ST_BYTE;
               end else if (stat.go_read) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_BYTE: begin
            cmd.load_byte = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (stat.hint_miss) begin
               cmd.rescan = 1'b1;
               state_in   = ST_BYTE;
            end else if (stat.rsp_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/bsa_datapath.sv @@
`timescale 1ns / 1ps

module bsa_datapath #(
   parameter int MAP_BYTES = bsa_pkg::BSA_MAP_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bsa_pkg::bsa_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bsa_pkg::bsa_rsp_type rsp_payload,
   input  bsa_pkg::bsa_cmd_type cmd,
   output bsa_pkg::bsa_stat_type stat
);
   import bsa_pkg::*;

   localparam int SLOT_COUNT = MAP_BYTES * 8;
   localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int SLOT_W     = AW + 3;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int XW         = SLOT_W + 8;
   localparam int NG         = (MAP_BYTES + BSA_GROUP_BYTES - 1) / BSA_GROUP_BYTES;
   localparam int GW         = (NG > 1) ? $clog2(NG) : 1;
   localparam int SW         = $clog2(BSA_GROUP_BYTES);
   localparam int PADW       = NG * BSA_GROUP_BYTES;

   typedef enum logic [2:0] {
      K_ALLOC_HINT,
      K_ALLOC_SCAN,
      K_FREE,
      K_FREE_BAD,
      K_FULL,
      K_CLEAR,
      K_NOP
   } bsa_kind_type;

   // map storage and its per-byte flags
   logic [7:0]           mem [MAP_BYTES];
   logic [7:0]           mem_q_ff;
   logic                 rd_valid_ff;
   logic [MAP_BYTES-1:0] row_valid_ff, row_valid_in;
   logic [MAP_BYTES-1:0] full_ff, full_in;

   // allocator state
   logic [CNT_W-1:0]  used_ff, used_in;
   logic              hint_valid_ff, hint_valid_in;
   logic [SLOT_W-1:0] hint_slot_ff, hint_slot_in;

   // request in flight
   bsa_kind_type      kind_ff, kind_in;
   logic [SLOT_W-1:0] slot_ff, target_slot;
   logic [AW-1:0]     addr_ff;
   logic [GW-1:0]     group_ff, group_pick;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   bsa_rsp_type rsp_ff, rsp_in;

   logic [XW-1:0]     slot_wide;
   logic [SLOT_W-1:0] slot_req;
   logic              slot_in_range;
   logic              map_full;

   logic [PADW-1:0]            full_pad;
   logic [NG-1:0]              group_full;
   logic [BSA_GROUP_BYTES-1:0] group_bits;
   logic [SW-1:0]              sub_pick;
   logic [GW+SW-1:0]           byte_wide;

   logic [7:0]  rd_data;
   logic [2:0]  bit_sel;
   logic [7:0]  bit_mask;
   logic        bit_busy;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic [SLOT_W-1:0]  grant_slot;
   logic [SLOT_W+7:0]  grant_wide;
   logic [CNT_W+8:0]   used_wide;

   // request slot, range checked against the map size
   assign slot_wide     = {{SLOT_W{1'b0}}, req_payload.slot_in};
   assign slot_req      = slot_wide[SLOT_W-1:0];
   assign slot_in_range = slot_wide < XW'(SLOT_COUNT);
   assign map_full      = used_ff >= CNT_W'(SLOT_COUNT);

   // decode of the incoming request, and status back to the controller
   always_comb begin
      kind_in      = K_NOP;
      target_slot  = slot_req;
      stat.go_scan = 1'b0;
      stat.go_read = 1'b0;
      unique case (req_payload.func)
         FUNC_ALLOC: begin
            if (map_full) begin
               kind_in = K_FULL;
            end else if (hint_valid_ff) begin
               kind_in      = K_ALLOC_HINT;
               target_slot  = hint_slot_ff;
               stat.go_read = 1'b1;
            end else begin
               kind_in      = K_ALLOC_SCAN;
               stat.go_scan = 1'b1;
            end
         end
         FUNC_FREE: begin
            if (slot_in_range) begin
               kind_in      = K_FREE;
               stat.go_read = 1'b1;
            end else begin
               kind_in = K_FREE_BAD;
            end
         end
         FUNC_CLEAR: begin
            kind_in = K_CLEAR;
         end
         default: begin
            kind_in = K_NOP;
         end
      endcase
      stat.hint_miss = (kind_ff == K_ALLOC_HINT) && bit_busy;
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // first group holding a byte with a free slot; missing bytes count as full
   always_comb begin
      full_pad                  = '1;
      full_pad[MAP_BYTES-1:0]   = full_ff;
      for (int g = 0; g < NG; g++) begin
         group_full[g] = &full_pad[g*BSA_GROUP_BYTES +: BSA_GROUP_BYTES];
      end
      group_pick = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (!group_full[g]) begin
            group_pick = GW'(g);
         end
      end
   end

   // first byte with a free slot inside the chosen group
   always_comb begin
      group_bits = full_pad[group_ff*BSA_GROUP_BYTES +: BSA_GROUP_BYTES];
      sub_pick   = '0;
      for (int s = BSA_GROUP_BYTES - 1; s >= 0; s--) begin
         if (!group_bits[s]) begin
            sub_pick = SW'(s);
         end
      end
      byte_wide = {group_ff, sub_pick};
   end

   // byte under work; a row never written since clear reads as empty
   assign rd_data = rd_valid_ff ? mem_q_ff : 8'h00;

   // bit under work: lowest free bit on a scan, else the slot's own bit
   always_comb begin
      bit_sel = slot_ff[2:0];
      if (kind_ff == K_ALLOC_SCAN) begin
         bit_sel = 3'd0;
         for (int k = 7; k >= 0; k--) begin
            if (!rd_data[k]) begin
               bit_sel = 3'(k);
            end
         end
      end
      bit_mask = 8'h01 << bit_sel;
      bit_busy = |(rd_data & bit_mask);
   end

   assign grant_slot     = {addr_ff, bit_sel};

   // state update and response for the finished request
   always_comb begin
      row_valid_in  = row_valid_ff;
      full_in       = full_ff;
      used_in       = used_ff;
      hint_valid_in = hint_valid_ff;
      hint_slot_in  = hint_slot_ff;
      mem_we        = 1'b0;
      mem_wdata     = rd_data | bit_mask;
      grant_wide    = '0;
      rsp_in.status = STATUS_OK;

      // a hinted allocate uses up the hint as soon as it is taken
      if (cmd.accept && kind_in == K_ALLOC_HINT) begin
         hint_valid_in = 1'b0;
      end

      if (cmd.update) begin
         unique case (kind_ff)
            K_ALLOC_HINT, K_ALLOC_SCAN: begin
               mem_we            = 1'b1;
               mem_wdata         = rd_data | bit_mask;
               row_valid_in[addr_ff] = 1'b1;
               full_in[addr_ff]  = (mem_wdata == 8'hFF);
               used_in           = used_ff + CNT_W'(1);
               grant_wide        = {8'h00, grant_slot};
            end
            K_FREE: begin
               if (bit_busy) begin
                  mem_we            = 1'b1;
                  mem_wdata         = rd_data & ~bit_mask;
                  row_valid_in[addr_ff] = 1'b1;
                  full_in[addr_ff]  = 1'b0;
                  used_in           = used_ff - CNT_W'(1);
                  hint_valid_in     = 1'b1;
                  hint_slot_in      = slot_ff;
               end else begin
                  rsp_in.status = STATUS_NOT_USED;
               end
            end
            K_FREE_BAD: begin
               rsp_in.status = STATUS_NOT_USED;
            end
            K_FULL: begin
               rsp_in.status = STATUS_FULL;
            end
            K_CLEAR: begin
               row_valid_in  = '0;
               full_in       = '0;
               used_in       = '0;
               hint_valid_in = 1'b0;
               hint_slot_in  = '0;
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
      end

      used_wide          = {9'h000, used_in};
      rsp_in.slot_out    = grant_wide[7:0];
      rsp_in.used_count  = used_wide[8:0];

      // response register: load on update, empty once taken
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff  <= '0;
         full_ff       <= '0;
         used_ff       <= '0;
         hint_valid_ff <= 1'b0;
         hint_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff  <= row_valid_in;
         full_ff       <= full_in;
         used_ff       <= used_in;
         hint_valid_ff <= hint_valid_in;
         hint_slot_ff  <= hint_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= kind_in;
         slot_ff  <= target_slot;
         addr_ff  <= target_slot[SLOT_W-1:3];
         group_ff <= group_pick;
      end else begin
         if (cmd.rescan) begin
            kind_ff <= K_ALLOC_SCAN;
         end
         if (cmd.load_byte) begin
            addr_ff <= byte_wide[AW-1:0];
         end
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   // map memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (cmd.read) begin
         mem_q_ff    <= mem[addr_ff];
         rd_valid_ff <= row_valid_ff[addr_ff];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/bitmap_slot_allocator.sv @@
`timescale 1ns / 1ps

// Slot allocator over an occupancy bitmap of MAP_BYTES bytes, eight slots to
// a byte, with a used-slot count and a one-entry hint of the slot freed last.
// One request is worked on at a time, and each gives one response. An
// allocate that searches for the lowest free slot passes through accept, byte
// selection from the per-byte full flags, registered read of the map memory
// and read-modify-write; a hinted allocate or a free of a slot inside the map
// skips the byte selection; a full map, a clear, a free beyond the map or an
// unused request code goes from accept straight to the update. A hinted slot
// found busy goes back through the scan's steps. The response sits in an
// output register, so a request is taken while the previous response still
// waits, and the update waits while that response is held. Clear empties the
// map through per-byte valid flags; there is no clearing pass after reset.

module bitmap_slot_allocator #(
   parameter int MAP_BYTES = bsa_pkg::BSA_MAP_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsa_pkg::bsa_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bsa_pkg::bsa_rsp_type rsp_payload
);
   import bsa_pkg::*;

   bsa_cmd_type  cmd;
   bsa_stat_type stat;

   // sequencer
   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // map, count, hint and response register
   bsa_datapath #(
      .MAP_BYTES (MAP_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
